/* sv/htr_pkg.sv */
// Package for the HEVC tile rectangle unit: shared types and codes.
`timescale 1ns / 1ps
package htr_pkg;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_CFG     = 2'd1,
    ST_NON_UNIFORM = 2'd2,
    ST_RANGE       = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CFG_PIC_W   = 3'd0,
    CFG_PIC_H   = 3'd1,
    CFG_BLK     = 3'd2,
    CFG_COLS    = 3'd3,
    CFG_ROWS    = 3'd4,
    CFG_UNIFORM = 3'd5
  } cfg_idx_t;

  // Control that travels with an item down the pipeline.
  typedef struct packed {
    logic    valid;
    status_t status;
  } ctl_t;

  // One finished result.
  typedef struct packed {
    status_t     status;
    logic [14:0] tile_x;
    logic [14:0] tile_y;
    logic [14:0] tile_width;
    logic [14:0] tile_height;
  } res_t;

endpackage

/* sv/htr_ifs.sv */
// Channel interfaces of the HEVC tile rectangle unit.
`timescale 1ns / 1ps
interface htr_in_if;
  logic       valid;
  logic       ready;
  logic [9:0] tile_index;
  modport source (output valid, output tile_index, input ready);
  modport sink (input valid, input tile_index, output ready);
endinterface

interface htr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [14:0] tile_x;
  logic [14:0] tile_y;
  logic [14:0] tile_width;
  logic [14:0] tile_height;
  modport source (output valid, output status, output tile_x, output tile_y,
                  output tile_width, output tile_height, input ready);
  modport sink (input valid, input status, input tile_x, input tile_y,
                input tile_width, input tile_height, output ready);
endinterface

interface htr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [14:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/htr_div_cell.sv */
// One restoring-division cell: one quotient bit per lane per cycle while en is high.
`timescale 1ns / 1ps
module htr_div_cell #(
  parameter int L  = 1,
  parameter int DW = 16,
  parameter int VW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  htr_pkg::ctl_t ctl_i,
  input  logic [VW-1:0] div_i [L],
  input  logic [VW-1:0] rem_i [L],
  input  logic [DW-1:0] acc_i [L],
  output htr_pkg::ctl_t ctl_o,
  output logic [VW-1:0] rem_o [L],
  output logic [DW-1:0] acc_o [L]
);
  import htr_pkg::*;

  logic          valid_r;
  status_t       status_r;
  logic [VW-1:0] rem_r   [L];
  logic [DW-1:0] acc_r   [L];
  logic [VW-1:0] rem_nxt [L];
  logic [DW-1:0] acc_nxt [L];
  logic [VW:0]   trial   [L];
  logic          ge      [L];

  always_comb begin
    for (int l = 0; l < L; l++) begin
      trial[l] = {rem_i[l], acc_i[l][DW-1]};
      ge[l]    = trial[l] >= {1'b0, div_i[l]};
      rem_nxt[l] = ge[l] ? VW'(trial[l] - {1'b0, div_i[l]}) : trial[l][VW-1:0];
      acc_nxt[l] = {acc_i[l][DW-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status_r <= ctl_i.status;
      rem_r    <= rem_nxt;
      acc_r    <= acc_nxt;
    end
  end

  assign ctl_o = '{valid: valid_r, status: status_r};
  assign rem_o = rem_r;
  assign acc_o = acc_r;

endmodule

/* sv/htr_div_chain.sv */
// Chain of division cells: DW cells give quotient and remainder per lane.
`timescale 1ns / 1ps
module htr_div_chain #(
  parameter int L  = 1,
  parameter int DW = 16,
  parameter int VW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  htr_pkg::ctl_t ctl_i,
  input  logic [VW-1:0] div_i [L],
  input  logic [DW-1:0] dvd_i [L],
  output htr_pkg::ctl_t ctl_o,
  output logic [DW-1:0] quo_o [L],
  output logic [VW-1:0] rem_o [L]
);
  import htr_pkg::*;

  ctl_t          ctl_w [DW+1];
  logic [VW-1:0] rem_w [DW+1][L];
  logic [DW-1:0] acc_w [DW+1][L];

  assign ctl_w[0] = ctl_i;
  for (genvar l = 0; l < L; l++) begin : g_lane
    assign rem_w[0][l] = '0;
    assign acc_w[0][l] = dvd_i[l];
  end

  for (genvar i = 0; i < DW; i++) begin : g_cell
    htr_div_cell #(.L(L), .DW(DW), .VW(VW)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (ctl_w[i]),
      .div_i (div_i),
      .rem_i (rem_w[i]),
      .acc_i (acc_w[i]),
      .ctl_o (ctl_w[i+1]),
      .rem_o (rem_w[i+1]),
      .acc_o (acc_w[i+1])
    );
  end

  assign ctl_o = ctl_w[DW];
  assign quo_o = acc_w[DW];
  assign rem_o = rem_w[DW];

endmodule

/* sv/hevc_tile_rectangle_unit.sv */
// Top level of the HEVC tile rectangle unit.
// Maps a raster tile index to its pixel rectangle under uniform HEVC tile
// spacing. One item enters per cycle unless the pipeline holds. Items pass in
// order through a 16-cell division chain (column/row split and CTB counts), a
// multiply stage, a 21-cell division chain (tile boundaries), a scale stage,
// then a two-entry output queue. The pipeline only holds when that queue is
// full. Config writes take effect at once and must be made while idle.
`timescale 1ns / 1ps
module hevc_tile_rectangle_unit #(
  parameter int MAX_TILE_GRID   = 32,
  parameter int MAX_PICTURE_DIM = 16384
) (
  input logic  clk,
  input logic  rst_n,
  htr_in_if.sink    in_chan,
  htr_out_if.source out_chan,
  htr_cfg_if.sink   cfg_chan
);
  import htr_pkg::*;

  localparam logic [6:0]  MaxGrid = 7'(MAX_TILE_GRID);
  localparam logic [16:0] MaxDim  = 17'(MAX_PICTURE_DIM);
  localparam int D1 = 16;  // ceil-div dividend width
  localparam int D2 = 21;  // k*ctbs width

  // Configuration registers
  logic [14:0] pw_r, ph_r;
  logic [7:0]  bs_r;
  logic [5:0]  cols_r, rows_r;
  logic        uni_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pw_r   <= 15'd1920;
      ph_r   <= 15'd1080;
      bs_r   <= 8'd64;
      cols_r <= 6'd1;
      rows_r <= 6'd1;
      uni_r  <= 1'b1;
    end else if (cfg_chan.valid) begin
      case (cfg_idx_t'(cfg_chan.index))
        CFG_PIC_W:   pw_r   <= cfg_chan.data;
        CFG_PIC_H:   ph_r   <= cfg_chan.data;
        CFG_BLK:     bs_r   <= cfg_chan.data[7:0];
        CFG_COLS:    cols_r <= cfg_chan.data[5:0];
        CFG_ROWS:    rows_r <= cfg_chan.data[5:0];
        CFG_UNIFORM: uni_r  <= cfg_chan.data[0];
        default: ;  // unknown register: ignored
      endcase
    end
  end

  // Pipeline advance: held only while the output queue is full.
  logic [1:0] cnt_r;
  logic       en;
  assign en = (cnt_r != 2'd2);
  assign in_chan.ready = en;

  // Entry: status check
  logic        bad_cfg;
  logic [11:0] n_tiles;
  ctl_t        ctl_in;
  always_comb begin
    n_tiles = 12'(cols_r) * 12'(rows_r);
    bad_cfg = (bs_r == 8'd0) || (cols_r == 6'd0) || (rows_r == 6'd0) ||
              ({1'b0, cols_r} > MaxGrid) || ({1'b0, rows_r} > MaxGrid) ||
              ({2'b0, pw_r} > MaxDim) || ({2'b0, ph_r} > MaxDim);
    ctl_in.valid = in_chan.valid;
    if (!uni_r)
      ctl_in.status = ST_NON_UNIFORM;
    else if (bad_cfg)
      ctl_in.status = ST_BAD_CFG;
    else if ({2'b0, in_chan.tile_index} >= n_tiles)
      ctl_in.status = ST_RANGE;
    else
      ctl_in.status = ST_OK;
  end

  // Chain 1: index / columns, ceil(width / ctb), ceil(height / ctb)
  logic [7:0]    div1 [3];
  logic [D1-1:0] dvd1 [3];
  logic [D1-1:0] quo1 [3];
  logic [7:0]    rem1 [3];
  ctl_t          ctl1;

  assign div1[0] = {2'b0, cols_r};
  assign div1[1] = bs_r;
  assign div1[2] = bs_r;
  assign dvd1[0] = {6'b0, in_chan.tile_index};
  assign dvd1[1] = D1'(17'(pw_r) + 17'(bs_r) - 17'd1);
  assign dvd1[2] = D1'(17'(ph_r) + 17'(bs_r) - 17'd1);

  htr_div_chain #(.L(3), .DW(D1), .VW(8)) u_chain1 (
    .clk (clk), .rst_n (rst_n), .en (en),
    .ctl_i (ctl_in), .div_i (div1), .dvd_i (dvd1),
    .ctl_o (ctl1), .quo_o (quo1), .rem_o (rem1)
  );

  // Multiply: boundary numerators k*ctbs and (k+1)*ctbs
  logic          m1_valid_r;
  status_t       m1_status_r;
  logic [D2-1:0] dvd2_r [4];
  logic [5:0]    col, row;
  logic [14:0]   ctw, cth;
  assign col = rem1[0][5:0];
  assign row = quo1[0][5:0];
  assign ctw = quo1[1][14:0];
  assign cth = quo1[2][14:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_valid_r <= 1'b0;
    end else if (en) begin
      m1_valid_r <= ctl1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_status_r <= ctl1.status;
      dvd2_r[0] <= D2'(22'(col) * 22'(ctw));
      dvd2_r[1] <= D2'((22'(col) + 22'd1) * 22'(ctw));
      dvd2_r[2] <= D2'(22'(row) * 22'(cth));
      dvd2_r[3] <= D2'((22'(row) + 22'd1) * 22'(cth));
    end
  end

  // Chain 2: boundaries lo/hi for both dimensions
  logic [7:0]    div2 [4];
  logic [D2-1:0] quo2 [4];
  logic [7:0]    rem2 [4];
  ctl_t          ctl2;
  assign div2[0] = {2'b0, cols_r};
  assign div2[1] = {2'b0, cols_r};
  assign div2[2] = {2'b0, rows_r};
  assign div2[3] = {2'b0, rows_r};

  htr_div_chain #(.L(4), .DW(D2), .VW(8)) u_chain2 (
    .clk (clk), .rst_n (rst_n), .en (en),
    .ctl_i ('{valid: m1_valid_r, status: m1_status_r}),
    .div_i (div2), .dvd_i (dvd2_r),
    .ctl_o (ctl2), .quo_o (quo2), .rem_o (rem2)
  );

  // Scale to pixels
  logic        m2_valid_r;
  status_t     m2_status_r;
  logic [22:0] sx_r, zx_r, sy_r, zy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_valid_r <= 1'b0;
    end else if (en) begin
      m2_valid_r <= ctl2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_status_r <= ctl2.status;
      sx_r <= 23'(quo2[0][14:0]) * 23'(bs_r);
      zx_r <= 23'(15'(quo2[1][14:0] - quo2[0][14:0])) * 23'(bs_r);
      sy_r <= 23'(quo2[2][14:0]) * 23'(bs_r);
      zy_r <= 23'(15'(quo2[3][14:0] - quo2[2][14:0])) * 23'(bs_r);
    end
  end

  // Clip to picture, zero fields on error
  logic [14:0] cx, cy, cw, ch;
  res_t        res;
  always_comb begin
    cx = (sx_r > 23'(pw_r)) ? pw_r : sx_r[14:0];
    cy = (sy_r > 23'(ph_r)) ? ph_r : sy_r[14:0];
    cw = ((24'(cx) + 24'(zx_r)) > 24'(pw_r)) ? 15'(pw_r - cx) : zx_r[14:0];
    ch = ((24'(cy) + 24'(zy_r)) > 24'(ph_r)) ? 15'(ph_r - cy) : zy_r[14:0];
    res.status = m2_status_r;
    if (m2_status_r == ST_OK) begin
      res.tile_x = cx;
      res.tile_y = cy;
      res.tile_width  = cw;
      res.tile_height = ch;
    end else begin
      res.tile_x = '0;
      res.tile_y = '0;
      res.tile_width  = '0;
      res.tile_height = '0;
    end
  end

  // Two-entry output queue
  res_t ent_r [2];
  logic wr_r, rd_r;
  logic push, pop;
  assign push = m2_valid_r && en;
  assign pop  = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
    end else begin
      cnt_r <= 2'(cnt_r + {1'b0, push} - {1'b0, pop});
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_r] <= res;
  end

  assign out_chan.valid       = (cnt_r != 2'd0);
  assign out_chan.status      = ent_r[rd_r].status;
  assign out_chan.tile_x      = ent_r[rd_r].tile_x;
  assign out_chan.tile_y      = ent_r[rd_r].tile_y;
  assign out_chan.tile_width  = ent_r[rd_r].tile_width;
  assign out_chan.tile_height = ent_r[rd_r].tile_height;

  // Assertions
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("output queue overfilled");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wr_r == rd_r))
    else $error("queue pointers out of step with count");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.status != ST_OK) |->
      (out_chan.tile_x == 15'd0 && out_chan.tile_y == 15'd0 &&
       out_chan.tile_width == 15'd0 && out_chan.tile_height == 15'd0))
    else $error("error result carries a rectangle");

endmodule

/* tb/htr_tb_pkg.sv */
// Testbench package: holds the drain wait used before configuration changes.
`timescale 1ns / 1ps
package htr_tb_pkg;
  import htr_pkg::*;
  localparam int DRAIN_CYCLES = 60;
endpackage

/* tb/testbench.sv */
// Self-checking testbench for the HEVC tile rectangle unit: directed and random tile queries.
`timescale 1ns / 1ps
module testbench;
  import htr_pkg::*;
  import htr_tb_pkg::*;

  localparam int MAX_GRID = 32;
  localparam int MAX_DIM  = 16384;
  localparam int WATCHDOG = 2000;

  logic clk;
  logic rst_n;

  htr_in_if  in_chan ();
  htr_out_if out_chan ();
  htr_cfg_if cfg_chan ();

  hevc_tile_rectangle_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_chan(in_chan), .out_chan(out_chan), .cfg_chan(cfg_chan)
  );

  // 10 ns clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Shadow copy of the register file
  int unsigned pic_w, pic_h, blk, cols, rows, uni;

  res_t rect_q[$];
  int   mismatches;
  int   idle_cycles;
  bit   out_taken;

  // One axis: start and clipped size of tile k out of n
  function automatic void tile_span(input int unsigned pic, input int unsigned bs,
                                    input int unsigned n, input int unsigned k,
                                    output int unsigned st, output int unsigned sz);
    int unsigned ctbs, lo, hi;
    ctbs = (pic + bs - 1) / bs;
    lo = (k * ctbs) / n;
    hi = ((k + 1) * ctbs) / n;
    st = lo * bs;
    sz = (hi - lo) * bs;
    if (st > pic) st = pic;
    if (st + sz > pic) sz = pic - st;
  endfunction

  function automatic res_t tile_rect(input logic [9:0] idx);
    res_t r;
    int unsigned x, y, w, h;
    r = '0;
    if (uni == 0) r.status = ST_NON_UNIFORM;
    else if (blk == 0 || cols == 0 || rows == 0 || cols > MAX_GRID || rows > MAX_GRID ||
             pic_w > MAX_DIM || pic_h > MAX_DIM) r.status = ST_BAD_CFG;
    else if (idx >= cols * rows) r.status = ST_RANGE;
    else begin
      r.status = ST_OK;
      tile_span(pic_w, blk, cols, idx % cols, x, w);
      tile_span(pic_h, blk, rows, idx / cols, y, h);
      r.tile_x = x[14:0];
      r.tile_y = y[14:0];
      r.tile_width = w[14:0];
      r.tile_height = h[14:0];
    end
    return r;
  endfunction

  // Drive idle values from time zero
  initial begin
    in_chan.valid = 1'b0;
    in_chan.tile_index = '0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = CFG_PIC_W;
    cfg_chan.data = '0;
    out_chan.ready = 1'b0;
  end

  // Send one tile index after a random gap, predicting its rectangle on acceptance.
  // Valid stays up after acceptance so a zero gap gives back-to-back items.
  task automatic send_index(input logic [9:0] idx);
    int unsigned gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.tile_index <= idx;
    do @(posedge clk); while (!in_chan.ready);
    rect_q.push_back(tile_rect(idx));
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data <= val[14:0];
    do @(posedge clk); while (!cfg_chan.ready);
    case (idx)
      CFG_PIC_W:   pic_w = val & 16'h7fff;
      CFG_PIC_H:   pic_h = val & 16'h7fff;
      CFG_BLK:     blk = val & 8'hff;
      CFG_COLS:    cols = val & 6'h3f;
      CFG_ROWS:    rows = val & 6'h3f;
      CFG_UNIFORM: uni = val & 1;
      default: ;
    endcase
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  // Drop the input and wait for the pipeline to drain before touching registers
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (rect_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_grid(input int unsigned w, input int unsigned h, input int unsigned b,
                          input int unsigned c, input int unsigned r, input int unsigned u);
    wait_idle();
    write_reg(CFG_PIC_W, w);
    write_reg(CFG_PIC_H, h);
    write_reg(CFG_BLK, b);
    write_reg(CFG_COLS, c);
    write_reg(CFG_ROWS, r);
    write_reg(CFG_UNIFORM, u);
  endtask

  // Reset settings, index edges and out-of-range
  task automatic test_reset_defaults();
    send_index(10'd0);
    send_index(10'd1);
    send_index(10'h3ff);
  endtask

  // Every error status, zero picture and oversized CTB
  task automatic test_special_cases();
    set_grid(1920, 1080, 64, 4, 3, 0);  // non-uniform
    send_index(10'd0);
    set_grid(1920, 1080, 0, 4, 3, 1);   // zero CTB
    send_index(10'd0);
    set_grid(1920, 1080, 64, 0, 3, 1);
    send_index(10'd0);
    set_grid(1920, 1080, 64, 4, 0, 1);
    send_index(10'd0);
    set_grid(1920, 1080, 64, 33, 63, 1); // grid over limit
    send_index(10'd5);
    set_grid(16385, 32767, 64, 2, 2, 1); // picture over limit
    send_index(10'd0);
    set_grid(0, 0, 64, 2, 2, 1);        // zero picture
    send_index(10'd3);
    set_grid(16384, 16384, 255, 32, 32, 1); // largest sizes, big CTB
    send_index(10'd0);
    send_index(10'd1023);
    send_index(10'd500);
    set_grid(100, 70, 128, 3, 2, 1);    // more tiles than CTBs
    for (int i = 0; i < 7; i++) send_index(i[9:0]);
    // unknown register index is ignored
    wait_idle();
    write_reg(cfg_idx_t'(3'd7), 15'h7fff);
    send_index(10'd2);
  endtask

  task automatic test_random();
    int unsigned c, r;
    for (int ph = 0; ph < 30; ph++) begin
      c = $urandom_range(1, 32);
      r = $urandom_range(1, 32);
      if ($urandom_range(0, 9) == 0) c = $urandom_range(0, 63);
      set_grid($urandom_range(0, 9) == 0 ? $urandom_range(0, 32767) : $urandom_range(0, 16384),
               $urandom_range(0, 16384),
               $urandom_range(0, 19) == 0 ? 0 : $urandom_range(1, 255),
               c, r, $urandom_range(0, 14) != 0);
      for (int i = 0; i < 20; i++)
        send_index($urandom_range(0, 3) == 0 ? 10'($urandom_range(0, 1023))
                   : 10'($urandom_range(0, (c * r > 0 ? c * r - 1 : 0))));
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    res_t exp_r;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      out_taken = 1'b1;
      if (rect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status=%0d", out_chan.status);
      end else begin
        exp_r = rect_q.pop_front();
        if (out_chan.status !== exp_r.status || out_chan.tile_x !== exp_r.tile_x ||
            out_chan.tile_y !== exp_r.tile_y || out_chan.tile_width !== exp_r.tile_width ||
            out_chan.tile_height !== exp_r.tile_height) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                     exp_r.status, exp_r.tile_x, exp_r.tile_y, exp_r.tile_width,
                     exp_r.tile_height, out_chan.status, out_chan.tile_x, out_chan.tile_y,
                     out_chan.tile_width, out_chan.tile_height);
        end
      end
    end
  end

  // Output side stall: after each accepted item, ready is held low while a random stall count runs down
  int stall_left;
  always @(negedge clk) begin
    if (!rst_n) out_chan.ready <= 1'b0;
    else if (out_taken) begin
      out_taken = 1'b0;
      stall_left = $urandom_range(0, 3);
      out_chan.ready <= (stall_left == 0);
    end else if (!out_chan.ready) begin
      if (stall_left > 0) stall_left--;
      out_chan.ready <= (stall_left == 0);
    end
  end

  // Watchdog on cycles with no handshake while anything is pending
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready) ||
        (rect_q.size() == 0 && !in_chan.valid && !cfg_chan.valid))
      idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    idle_cycles = 0;
    stall_left = 0;
    out_taken = 1'b0;
    pic_w = 1920; pic_h = 1080; blk = 64; cols = 1; rows = 1; uni = 1;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_special_cases();
    test_random();
    wait_idle();
    if (mismatches == 0 && rect_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
